>>> design/hidkbd_pkg.sv
// Shared types and constants of the keyboard report differ.
package hidkbd_pkg;

  localparam int unsigned CarriedSlots = 6;
  localparam int unsigned ModBits      = 8;
  localparam int unsigned KeyIdxW      = $clog2(CarriedSlots);

  localparam logic [7:0] ModBase      = 8'hE0;
  localparam logic [7:0] RolloverCode = 8'h01;
  localparam logic [7:0] EmptyCode    = 8'h00;

  typedef struct packed {
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } report_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic       is_press;
    logic       event_valid;
    logic       last_of_report;
  } event_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the incoming report
    logic eval;       // build the change mask
    logic step;       // advance one candidate position
    logic emit_done;  // load the no-change marker
    logic commit;     // current report becomes previous report
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rollover;   // incoming report is a rollover report
    logic rem_zero;   // no change left to report
    logic cand;       // change at the current position
    logic last;       // no change after the current position
  } dp_sts_t;

endpackage

>>> design/hidkbd_if.sv
// Valid/ready channel interfaces for keyboard reports and key events.
interface hidkbd_report_if;
  logic                valid;
  logic                ready;
  hidkbd_pkg::report_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hidkbd_event_if;
  logic               valid;
  logic               ready;
  hidkbd_pkg::event_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/hid_keyboard_report_to_key_events.sv
// Top level of the keyboard report differ: reports in, key events out.
//
//   channel    modport  direction  carries
//   report_i   sink     in         modifier byte and six key slots per request
//   event_o    source   out        key code, press, event flag, last flag
//
// A report passes an accept state and a mask state, then steps through the
// candidate positions (16 modifier positions plus two per used slot, 28 with
// six slots) up to the last change; a stall on event_o holds the step.
// A rollover report is accepted in the idle state without a load and leaves no trace.
// The event register lets the next report in while the final event waits.
// Reset clears the stored report to all zero; no clearing pass is needed.
module hid_keyboard_report_to_key_events #(
  parameter int unsigned KeySlots = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  hidkbd_report_if.sink          report_i,
  hidkbd_event_if.source         event_o
);
  import hidkbd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence the scan and own both handshakes
  hidkbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (report_i.valid),
    .in_ready_o  (report_i.ready),
    .out_valid_o (event_o.valid),
    .out_ready_i (event_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold both reports, build the change mask, drive the event register
  hidkbd_datapath #(
    .KeySlots (KeySlots)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .report_i (report_i.data),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .evt_o    (event_o.data)
  );

endmodule

>>> design/hidkbd_ctrl.sv
// Sequencing controller of the keyboard report differ.
module hidkbd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  hidkbd_pkg::dp_sts_t sts_i,
  output hidkbd_pkg::dp_cmd_t cmd_o
);
  import hidkbd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;
  logic   finish;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign finish      = slot_free && (sts_i.rem_zero || (sts_i.cand && sts_i.last));

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        // drop rollover reports: accepted but never loaded
        cmd_o.load = in_valid_i && !sts_i.rollover;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
      end
      ST_SCAN: begin
        if (slot_free) begin
          if (sts_i.rem_zero) begin
            cmd_o.emit_done = 1'b1;
            cmd_o.commit    = 1'b1;
          end else begin
            cmd_o.step   = 1'b1;
            cmd_o.commit = sts_i.cand && sts_i.last;
          end
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && !sts_i.rollover) state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (finish) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase

      if (cmd_o.emit_done || (cmd_o.step && sts_i.cand)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> design/hidkbd_datapath.sv
// Report store, change mask and event register of the keyboard report differ.
module hidkbd_datapath #(
  parameter int unsigned KeySlots = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hidkbd_pkg::report_t report_i,
  input  hidkbd_pkg::dp_cmd_t cmd_i,
  output hidkbd_pkg::dp_sts_t sts_o,
  output hidkbd_pkg::event_t  evt_o
);
  import hidkbd_pkg::*;

  localparam int unsigned UsedSlots = (KeySlots < CarriedSlots) ? KeySlots : CarriedSlots;
  localparam int unsigned NumCand   = 2 * ModBits + 2 * UsedSlots;
  localparam int unsigned IdxW      = $clog2(NumCand);

  logic [7:0]         cur_mods_q;
  logic [7:0]         prev_mods_q;
  logic [7:0]         cur_keys_q  [CarriedSlots];
  logic [7:0]         prev_keys_q [CarriedSlots];
  logic [7:0]         in_keys     [CarriedSlots];
  logic [NumCand-1:0] rem_q;
  logic [NumCand-1:0] mask_d;
  logic [IdxW-1:0]    idx_q;
  logic [IdxW-1:0]    kidx;
  logic [IdxW-1:0]    kidx_cur;
  event_t             evt_q;

  logic [7:0]           rel_mod;
  logic [7:0]           prs_mod;
  logic [UsedSlots-1:0] pv;
  logic [UsedSlots-1:0] cv;
  logic [UsedSlots-1:0] rel_key;
  logic [UsedSlots-1:0] prs_key;
  logic                 found;
  logic                 run;

  logic [7:0] sel_code;
  logic       sel_press;

  assign in_keys[0] = report_i.key_slot_0;
  assign in_keys[1] = report_i.key_slot_1;
  assign in_keys[2] = report_i.key_slot_2;
  assign in_keys[3] = report_i.key_slot_3;
  assign in_keys[4] = report_i.key_slot_4;
  assign in_keys[5] = report_i.key_slot_5;

  assign rel_mod = prev_mods_q & ~cur_mods_q;
  assign prs_mod = ~prev_mods_q & cur_mods_q;

  // Listed slots: those before the first empty slot
  always_comb begin
    run = 1'b1;
    for (int i = 0; i < UsedSlots; i++) begin
      run   = run && (prev_keys_q[i] != EmptyCode);
      pv[i] = run;
    end
    run = 1'b1;
    for (int i = 0; i < UsedSlots; i++) begin
      run   = run && (cur_keys_q[i] != EmptyCode);
      cv[i] = run;
    end
  end

  // Release: listed previous key absent from current list; press the other way round
  always_comb begin
    for (int i = 0; i < UsedSlots; i++) begin
      found = 1'b0;
      for (int j = 0; j < UsedSlots; j++) begin
        found = found || (cv[j] && (cur_keys_q[j] == prev_keys_q[i]));
      end
      rel_key[i] = pv[i] && !found;
      found = 1'b0;
      for (int j = 0; j < UsedSlots; j++) begin
        found = found || (pv[j] && (prev_keys_q[j] == cur_keys_q[i]));
      end
      prs_key[i] = cv[i] && !found;
    end
  end

  always_comb begin
    mask_d = '0;
    for (int i = 0; i < ModBits; i++) begin
      mask_d[i]           = rel_mod[i];
      mask_d[ModBits + i] = prs_mod[i];
    end
    for (int i = 0; i < UsedSlots; i++) begin
      mask_d[2 * ModBits + i]             = rel_key[i];
      mask_d[2 * ModBits + UsedSlots + i] = prs_key[i];
    end
  end

  // Code for the current candidate position
  assign kidx     = idx_q - IdxW'(2 * ModBits);
  assign kidx_cur = kidx - IdxW'(UsedSlots);

  always_comb begin
    priority if (idx_q < IdxW'(ModBits)) begin
      sel_code  = ModBase + {5'b0, idx_q[2:0]};
      sel_press = 1'b0;
    end else if (idx_q < IdxW'(2 * ModBits)) begin
      sel_code  = ModBase + {5'b0, idx_q[2:0]};
      sel_press = 1'b1;
    end else if (kidx < IdxW'(UsedSlots)) begin
      sel_code  = prev_keys_q[kidx[KeyIdxW-1:0]];
      sel_press = 1'b0;
    end else begin
      sel_code  = cur_keys_q[kidx_cur[KeyIdxW-1:0]];
      sel_press = 1'b1;
    end
  end

  assign sts_o.rollover = (report_i.key_slot_0 == RolloverCode);
  assign sts_o.rem_zero = (rem_q == '0);
  assign sts_o.cand     = rem_q[0];
  assign sts_o.last     = (rem_q[NumCand-1:1] == '0);
  assign evt_o          = evt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      idx_q       <= '0;
      prev_mods_q <= '0;
      for (int i = 0; i < CarriedSlots; i++) begin
        prev_keys_q[i] <= '0;
      end
    end else begin
      if (cmd_i.eval) begin
        rem_q <= mask_d;
        idx_q <= '0;
      end else if (cmd_i.step) begin
        rem_q <= rem_q >> 1;
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.commit) begin
        prev_mods_q <= cur_mods_q;
        for (int i = 0; i < CarriedSlots; i++) begin
          prev_keys_q[i] <= cur_keys_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_mods_q <= report_i.modifier_bits;
      for (int i = 0; i < CarriedSlots; i++) begin
        cur_keys_q[i] <= in_keys[i];
      end
    end
    if (cmd_i.emit_done) begin
      evt_q.key_code       <= EmptyCode;
      evt_q.is_press       <= 1'b0;
      evt_q.event_valid    <= 1'b0;
      evt_q.last_of_report <= 1'b1;
    end else if (cmd_i.step && rem_q[0]) begin
      evt_q.key_code       <= sel_code;
      evt_q.is_press       <= sel_press;
      evt_q.event_valid    <= 1'b1;
      evt_q.last_of_report <= (rem_q[NumCand-1:1] == '0);
    end
  end

endmodule

>>> tb/hidkbd_event_checker.sv
// Checker for the keyboard report differ: predicts key events per report and compares them.
module hidkbd_event_checker #(
  parameter int unsigned KeySlots = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        end_check_i,
  hidkbd_report_if    report_mon,
  hidkbd_event_if     event_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import hidkbd_pkg::*;

  localparam int unsigned UsedSlots = (KeySlots < CarriedSlots) ? KeySlots : CarriedSlots;

  logic [7:0]       held_mods;
  logic [0:5][7:0]  held_keys;
  event_t           key_events_due[$];
  int unsigned      mismatches;
  int unsigned      events_seen;
  bit               swept;

  task automatic flag_mismatch(string what);
    $display("[%0t] mismatch at event %0d: %s", $time, events_seen, what);
    mismatches++;
  endtask

  // A key counts as listed only up to the first empty slot.
  function automatic bit listed(logic [0:5][7:0] list, logic [7:0] code);
    for (int i = 0; i < UsedSlots; i++) begin
      if (list[i] == EmptyCode) return 1'b0;
      if (list[i] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void queue_event(logic [7:0] code, logic press, logic valid);
    key_events_due.push_back({code, press, valid, 1'b0});
  endfunction

  task automatic diff_against_held(report_t r);
    logic [7:0]      mods;
    logic [7:0]      gone;
    logic [7:0]      added;
    logic [0:5][7:0] slots;
    int unsigned     first;
    event_t          tail;
    {mods, slots} = r;
    if (slots[0] == RolloverCode) return;
    first = key_events_due.size();
    gone  = held_mods & ~mods;
    added = ~held_mods & mods;
    for (int b = 0; b < ModBits; b++)
      if (gone[b]) queue_event(ModBase + 8'(b), 1'b0, 1'b1);
    for (int b = 0; b < ModBits; b++)
      if (added[b]) queue_event(ModBase + 8'(b), 1'b1, 1'b1);
    for (int i = 0; i < UsedSlots; i++) begin
      if (held_keys[i] == EmptyCode) break;
      if (!listed(slots, held_keys[i])) queue_event(held_keys[i], 1'b0, 1'b1);
    end
    for (int i = 0; i < UsedSlots; i++) begin
      if (slots[i] == EmptyCode) break;
      if (!listed(held_keys, slots[i])) queue_event(slots[i], 1'b1, 1'b1);
    end
    held_mods = mods;
    held_keys = slots;
    // an unchanged report still owes the matrix-update marker
    if (key_events_due.size() == first) queue_event(EmptyCode, 1'b0, 1'b0);
    tail = key_events_due.pop_back();
    tail.last_of_report = 1'b1;
    key_events_due.push_back(tail);
  endtask

  task automatic check_event(event_t got);
    event_t want;
    if (key_events_due.size() == 0) begin
      flag_mismatch($sformatf("event code %02h press %0b valid %0b last %0b with none due",
                              got.key_code, got.is_press, got.event_valid,
                              got.last_of_report));
      return;
    end
    want = key_events_due.pop_front();
    if (got.key_code !== want.key_code)
      flag_mismatch($sformatf("key_code %02h, want %02h", got.key_code, want.key_code));
    if (got.is_press !== want.is_press)
      flag_mismatch($sformatf("is_press %0b, want %0b", got.is_press, want.is_press));
    if (got.event_valid !== want.event_valid)
      flag_mismatch($sformatf("event_valid %0b, want %0b", got.event_valid,
                              want.event_valid));
    if (got.last_of_report !== want.last_of_report)
      flag_mismatch($sformatf("last_of_report %0b, want %0b", got.last_of_report,
                              want.last_of_report));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_mods = '0;
      held_keys = '0;
      key_events_due.delete();
      mismatches  = 0;
      events_seen = 0;
      swept       = 1'b0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // events of a newly taken report cannot leave in the same cycle
      if (event_mon.valid && event_mon.ready) begin
        check_event(event_mon.data);
        events_seen++;
      end
      if (report_mon.valid && report_mon.ready) diff_against_held(report_mon.data);
      if (end_check_i && !swept) begin
        while (key_events_due.size() != 0) begin
          flag_mismatch($sformatf("event code %02h never arrived",
                                  key_events_due[0].key_code));
          void'(key_events_due.pop_front());
        end
        swept = 1'b1;
      end
      fail_count_o <= mismatches;
      pending_o    <= key_events_due.size();
    end
  end

endmodule

>>> tb/tb_hid_keyboard_report_to_key_events.sv
// Testbench top: drives keyboard report requests, stalls the event side, gives the verdict.
module tb_hid_keyboard_report_to_key_events;
  import hidkbd_pkg::*;

  localparam int unsigned RandomReports = 160;
  // Slowest run: ~180 reports, each with a full scan and up to 28 events at a
  // heavily stalled receiver; take that several times over.
  localparam int unsigned CycleLimit    = 400000;
  // Scan length of one report plus margin.
  localparam int unsigned DrainCycles   = 64;

  logic        clk_i;
  logic        rst_ni;
  logic        end_check;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycles;
  report_t     held_report;

  hidkbd_report_if report_ch ();
  hidkbd_event_if  event_ch ();

  hid_keyboard_report_to_key_events #(
    .KeySlots (6)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .report_i (report_ch),
    .event_o  (event_ch)
  );

  hidkbd_event_checker #(
    .KeySlots (6)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .end_check_i  (end_check),
    .report_mon   (report_ch),
    .event_mon    (event_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: give up once the run has gone far past its slowest plausible length.
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Receiver side: drop ready at random at the rate of the current phase.
  initial begin
    event_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      event_ch.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one report request after a random idle gap and hold it until taken.
  // Valid stays high between back-to-back requests so it is never lowered and
  // raised in the same step.
  task automatic send_report(report_t r);
    while ($urandom_range(99) < idle_pct) begin
      report_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    report_ch.valid <= 1'b1;
    report_ch.data  <= r;
    @(posedge clk_i);
    while (!report_ch.ready) @(posedge clk_i);
    // a rollover request leaves the stored report untouched, so keep ours too
    if (r.key_slot_0 != RolloverCode) held_report = r;
  endtask

  // Build the next random report. Most are small edits of the held report, so
  // that keys stay held across reports and overlap; the rest are repeats,
  // rollover requests and plain noise.
  function automatic report_t next_report(report_t held);
    logic [7:0]      mods;
    logic [0:5][7:0] slots;
    logic [7:0]      kept[$];
    int unsigned     pick;
    {mods, slots} = held;
    pick = $urandom_range(99);
    if (pick < 10) begin
      // rollover: slot 0 carries the error code, the rest is noise
      slots[0] = RolloverCode;
      for (int i = 1; i < CarriedSlots; i++) slots[i] = 8'($urandom);
    end else if (pick < 22) begin
      // resend the held report unchanged: only the marker comes back
    end else if (pick < 42) begin
      mods = 8'($urandom);
      for (int i = 0; i < CarriedSlots; i++)
        slots[i] = ($urandom_range(4) == 0) ? EmptyCode : 8'($urandom);
    end else begin
      // toggle a few modifier bits, drop some held keys, add a few new ones
      mods ^= 8'($urandom & $urandom);
      for (int i = 0; i < CarriedSlots; i++) begin
        if (slots[i] == EmptyCode) break;
        if ($urandom_range(3) != 0) kept.push_back(slots[i]);
      end
      repeat ($urandom_range(2)) begin
        if (kept.size() < CarriedSlots)
          kept.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255, 2))
                                                  : 8'($urandom_range(24, 4)));
      end
      slots = '0;
      foreach (kept[i]) slots[i] = kept[i];
    end
    return {mods, slots};
  endfunction

  initial begin
    rst_ni          <= 1'b0;
    end_check       <= 1'b0;
    report_ch.valid <= 1'b0;
    report_ch.data  <= '0;
    idle_pct    = 10;
    stall_pct   = 71;
    held_report = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    send_report({8'h00, 48'h00_00_00_00_00_00});  // same as reset state: marker only
    send_report({8'hFF, 48'h00_00_00_00_00_00});  // every modifier pressed
    send_report({8'h00, 48'h00_00_00_00_00_00});  // every modifier released
    send_report({8'hA5, 48'h04_05_06_07_08_09});  // full key list
    send_report({8'h5A, 48'h01_01_01_01_01_01});  // rollover: ignored
    send_report({8'hA5, 48'h04_05_06_07_08_09});  // unchanged after rollover
    send_report({8'h5A, 48'hFF_FE_E0_E7_02_03});  // everything swaps: longest burst
    send_report({8'h5A, 48'h02_00_FF_FE_E0_E7});  // list ends early, tail stored
    send_report({8'h5A, 48'h00_11_22_33_44_55});  // empty list with junk behind it
    send_report({8'h5A, 48'h11_00_00_00_00_00});  // stored junk must not count
    send_report({8'h5A, 48'h11_11_11_00_00_00});  // repeated code, already held
    send_report({8'h5A, 48'h22_22_00_00_00_00});  // repeats release three times and press twice
    send_report({8'h00, 48'h01_00_00_00_00_00});  // rollover with modifier change
    send_report({8'h5A, 48'h22_01_33_00_00_00});  // code 1 outside slot 0 is a key
    send_report({8'h80, 48'hFF_FF_FF_FF_FF_FF});  // top values everywhere
    send_report({8'h01, 48'h00_00_00_00_00_00});
    send_report({8'h00, 48'h00_00_00_00_00_00});

    // Random part in three idling phases: sender light / receiver heavy,
    // then the reverse, then neither idles.
    for (int i = 0; i < RandomReports; i++) begin
      if (i == RandomReports / 3) begin
        idle_pct  = 71;
        stall_pct = 10;
      end
      if (i == 2 * RandomReports / 3) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      send_report(next_report(held_report));
    end
    report_ch.valid <= 1'b0;

    // The checker's count is registered, so advance once before trusting it.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    end_check <= 1'b1;
    repeat (2) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
